### hw/rtl/slms_pkg.sv
// Package: shared widths, LED bits, register indexes and configuration types.
package slms_pkg;

  localparam int unsigned TimeBitsDflt = 48;
  localparam int unsigned CfgW         = 24;
  localparam int unsigned CycW         = 16;
  localparam int unsigned LedW         = 3;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [LedW-1:0] LedCtrl = 3'b001;
  localparam logic [LedW-1:0] LedPump = 3'b010;
  localparam logic [LedW-1:0] LedRain = 3'b100;
  localparam logic [LedW-1:0] LedAll  = 3'b111;
  localparam logic [LedW-1:0] LedNone = 3'b000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATT_ON   = 3'd0,
    CFG_ATT_OFF  = 3'd1,
    CFG_AP_ON    = 3'd2,
    CFG_AP_OFF   = 3'd3,
    CFG_PUMP_HLD = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] attention_on_time;
    logic [CfgW-1:0] attention_off_time;
    logic [CfgW-1:0] ap_on_time;
    logic [CfgW-1:0] ap_off_time;
    logic [CfgW-1:0] pump_hold_time;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    attention_on_time:  24'd100000,
    attention_off_time: 24'd100000,
    ap_on_time:         24'd500000,
    ap_off_time:        24'd500000,
    pump_hold_time:     24'd1000000
  };

endpackage

### hw/rtl/slms_if.sv
// Interfaces: tick item channel, LED result channel and configuration write channel.
interface slms_tick_if #(
  parameter int unsigned TIME_BITS = slms_pkg::TimeBitsDflt
);
  logic                        valid;
  logic                        ready;
  logic [TIME_BITS-1:0]        now_time;
  logic                        attention;
  logic                        ap_mode;
  logic [slms_pkg::CycW-1:0]   pump_cycles;
  logic                        pump_request;
  logic [slms_pkg::CfgW-1:0]   control_request;
  logic [slms_pkg::CfgW-1:0]   pump_hold_request;

  modport source (
    output valid, now_time, attention, ap_mode, pump_cycles, pump_request,
           control_request, pump_hold_request,
    input  ready
  );
  modport sink (
    input  valid, now_time, attention, ap_mode, pump_cycles, pump_request,
           control_request, pump_hold_request,
    output ready
  );
endinterface

interface slms_led_if;
  logic                      valid;
  logic                      ready;
  logic [slms_pkg::LedW-1:0] led_mask;
  logic [slms_pkg::LedW-1:0] led_value;

  modport source (output valid, led_mask, led_value, input ready);
  modport sink (input valid, led_mask, led_value, output ready);
endinterface

interface slms_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [slms_pkg::CfgIdxW-1:0] index;
  logic [slms_pkg::CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/slms_cfg_regs.sv
// Configuration register file for the blink and hold times.
module slms_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  slms_cfg_if.sink       cfg_i,
  output slms_pkg::cfg_t cfg_o
);
  import slms_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ATT_ON:   cfg_d.attention_on_time  = cfg_i.data;
        CFG_ATT_OFF:  cfg_d.attention_off_time = cfg_i.data;
        CFG_AP_ON:    cfg_d.ap_on_time         = cfg_i.data;
        CFG_AP_OFF:   cfg_d.ap_off_time        = cfg_i.data;
        CFG_PUMP_HLD: cfg_d.pump_hold_time     = cfg_i.data;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/slms_engine.sv
// Mode engine: LED state registers and the per-tick update logic.
module slms_engine #(
  parameter int unsigned TIME_BITS = slms_pkg::TimeBitsDflt
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  slms_pkg::cfg_t            cfg_i,
  input  logic [TIME_BITS-1:0]      now_time_i,
  input  logic                      attention_i,
  input  logic                      ap_mode_i,
  input  logic [slms_pkg::CycW-1:0] pump_cycles_i,
  input  logic                      pump_request_i,
  input  logic [slms_pkg::CfgW-1:0] control_request_i,
  input  logic [slms_pkg::CfgW-1:0] pump_hold_request_i,
  output logic [slms_pkg::LedW-1:0] led_mask_o,
  output logic [slms_pkg::LedW-1:0] led_value_o
);
  import slms_pkg::*;

  localparam int unsigned PadW = TIME_BITS - CfgW;

  logic [TIME_BITS-1:0] blink_q, blink_d;
  logic                 att_ph_q, att_ph_d;
  logic                 ap_ph_q, ap_ph_d;
  logic                 ctrl_lit_q, ctrl_lit_d;
  logic [CfgW-1:0]      ctrl_dur_q, ctrl_dur_d;
  logic [TIME_BITS-1:0] ctrl_dl_q, ctrl_dl_d;
  logic                 pump_lit_q, pump_lit_d;
  logic                 pump_pend_q, pump_pend_d;
  logic [TIME_BITS-1:0] pump_dl_q, pump_dl_d;

  logic [CfgW-1:0]      blink_len;
  logic [TIME_BITS-1:0] blink_sum, hreq_sum, ctrl_sum, hold_sum;
  logic [CfgW-1:0]      dur_eff;
  logic [TIME_BITS-1:0] pdl_eff, cdl_eff;
  logic                 pend_eff;
  logic                 phase;
  logic [LedW-1:0]      mask, val;

  always_comb begin
    dur_eff  = (control_request_i != '0) ? control_request_i : ctrl_dur_q;
    pend_eff = pump_pend_q | pump_request_i;
    phase    = attention_i ? att_ph_q : ap_ph_q;
    case ({attention_i, phase})
      2'b11:   blink_len = cfg_i.attention_off_time;
      2'b10:   blink_len = cfg_i.attention_on_time;
      2'b01:   blink_len = cfg_i.ap_off_time;
      default: blink_len = cfg_i.ap_on_time;
    endcase
    blink_sum = now_time_i + {{PadW{1'b0}}, blink_len};
    hreq_sum  = now_time_i + {{PadW{1'b0}}, pump_hold_request_i};
    ctrl_sum  = now_time_i + {{PadW{1'b0}}, dur_eff};
    hold_sum  = now_time_i + {{PadW{1'b0}}, cfg_i.pump_hold_time};
    pdl_eff   = (pump_hold_request_i != '0) ? hreq_sum : pump_dl_q;
    cdl_eff   = (dur_eff != '0) ? ctrl_sum : ctrl_dl_q;
  end

  always_comb begin
    blink_d     = blink_q;
    att_ph_d    = att_ph_q;
    ap_ph_d     = ap_ph_q;
    ctrl_lit_d  = ctrl_lit_q;
    ctrl_dur_d  = dur_eff;
    ctrl_dl_d   = ctrl_dl_q;
    pump_lit_d  = pump_lit_q;
    pump_pend_d = pend_eff;
    pump_dl_d   = pdl_eff;
    mask        = LedNone;
    val         = LedNone;
    if (attention_i || ap_mode_i) begin
      if (now_time_i > blink_q) begin
        mask    = LedAll;
        blink_d = blink_sum;
        if (attention_i) begin
          val      = att_ph_q ? (LedCtrl | LedPump) : LedRain;
          att_ph_d = !att_ph_q;
        end else begin
          val     = ap_ph_q ? LedNone : LedAll;
          ap_ph_d = !ap_ph_q;
        end
      end
    end else begin
      ctrl_dur_d = '0;
      ctrl_dl_d  = cdl_eff;
      if (cdl_eff != '0) begin
        if (now_time_i > cdl_eff) begin
          if (ctrl_lit_q) begin
            mask       = mask | LedCtrl;
            ctrl_lit_d = 1'b0;
            ctrl_dl_d  = '0;
          end
        end else if (!ctrl_lit_q) begin
          mask       = mask | LedCtrl;
          val        = val | LedCtrl;
          ctrl_lit_d = 1'b1;
        end
      end else if (ctrl_lit_q) begin
        mask       = mask | LedCtrl;
        ctrl_lit_d = 1'b0;
      end

      if ((pump_cycles_i != '0) || pend_eff) begin
        if (!pump_lit_q) begin
          mask       = mask | LedPump;
          val        = val | LedPump;
          pump_lit_d = 1'b1;
        end
        pump_dl_d   = hold_sum;
        pump_pend_d = 1'b0;
      end else if ((pdl_eff != '0) && pump_lit_q && (now_time_i > pdl_eff)) begin
        mask       = mask | LedPump;
        pump_lit_d = 1'b0;
        pump_dl_d  = '0;
      end
    end
  end

  assign led_mask_o  = mask;
  assign led_value_o = val & mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q     <= '0;
      att_ph_q    <= 1'b0;
      ap_ph_q     <= 1'b0;
      ctrl_lit_q  <= 1'b0;
      ctrl_dur_q  <= '0;
      ctrl_dl_q   <= '0;
      pump_lit_q  <= 1'b0;
      pump_pend_q <= 1'b0;
      pump_dl_q   <= '0;
    end else if (step_i) begin
      blink_q     <= blink_d;
      att_ph_q    <= att_ph_d;
      ap_ph_q     <= ap_ph_d;
      ctrl_lit_q  <= ctrl_lit_d;
      ctrl_dur_q  <= ctrl_dur_d;
      ctrl_dl_q   <= ctrl_dl_d;
      pump_lit_q  <= pump_lit_d;
      pump_pend_q <= pump_pend_d;
      pump_dl_q   <= pump_dl_d;
    end
  end

endmodule

### hw/rtl/status_led_mode_sequencer_core.sv
// Top level: status LED mode sequencer with input and result registers.
//
//   port   | modport | moves
//   -------+---------+------------------------------------------------
//   in_i   | sink    | tick item: time, mode flags, pump and requests
//   out_o  | source  | LED update item: led_mask, led_value
//   cfg_i  | sink    | register write: index, data (always ready)
//
// One tick item per cycle sustained while the result is not stalled.
// The input register feeds the mode engine, whose state updates as the item
// moves into the result register; ticks that change no LED leave no item.
// A stalled result holds the input register; ready drops only while both are full.
// Reset clears all mode state and loads the default blink and hold times.
module status_led_mode_sequencer_core #(
  parameter int unsigned TIME_BITS = slms_pkg::TimeBitsDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slms_tick_if.sink   in_i,
  slms_led_if.source  out_o,
  slms_cfg_if.sink    cfg_i
);
  import slms_pkg::*;

  cfg_t cfg;

  logic                 in_vld_q, in_vld_d;
  logic [TIME_BITS-1:0] now_q;
  logic                 att_q, ap_q, preq_q;
  logic [CycW-1:0]      cyc_q;
  logic [CfgW-1:0]      creq_q, hreq_q;

  logic                 out_vld_q, out_vld_d;
  logic [LedW-1:0]      mask_q, value_q;
  logic [LedW-1:0]      mask, value;

  logic                 step, take;

  assign step        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || step;
  assign take        = in_i.valid && in_i.ready;
  assign in_vld_d    = take || (in_vld_q && !step);
  assign out_vld_d   = step ? (mask != LedNone) : (out_vld_q && !out_o.ready);

  assign out_o.valid     = out_vld_q;
  assign out_o.led_mask  = mask_q;
  assign out_o.led_value = value_q;

  slms_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  slms_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (step),
    .cfg_i               (cfg),
    .now_time_i          (now_q),
    .attention_i         (att_q),
    .ap_mode_i           (ap_q),
    .pump_cycles_i       (cyc_q),
    .pump_request_i      (preq_q),
    .control_request_i   (creq_q),
    .pump_hold_request_i (hreq_q),
    .led_mask_o          (mask),
    .led_value_o         (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      now_q  <= in_i.now_time;
      att_q  <= in_i.attention;
      ap_q   <= in_i.ap_mode;
      cyc_q  <= in_i.pump_cycles;
      preq_q <= in_i.pump_request;
      creq_q <= in_i.control_request;
      hreq_q <= in_i.pump_hold_request;
    end
    if (step) begin
      mask_q  <= mask;
      value_q <= value;
    end
  end

endmodule

### hw/rtl/slms_checker.sv
// Checker: port-level assertions for the status LED mode sequencer, bound to the top level.
module slms_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [slms_pkg::LedW-1:0] led_mask_i,
  input logic [slms_pkg::LedW-1:0] led_value_i
);
  import slms_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(led_mask_i) && $stable(led_value_i))
    else $error("stalled result item changed");

  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> led_mask_i != LedNone)
    else $error("result item writes no LED");

  a_value_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (led_value_i & ~led_mask_i) == LedNone)
    else $error("value bit set outside mask");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input taken while both registers are full");

endmodule

bind status_led_mode_sequencer_core slms_checker u_slms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .led_mask_i  (out_o.led_mask),
  .led_value_i (out_o.led_value)
);
